// ----- hdl/rc_pulse_capture_to_stick_angles_core_defines.svh -----
// Assertion macros shared by the RC pulse decoder RTL.
// No dependencies; the macros compile to nothing when SYNTHESIS is defined.
`ifndef RC_PULSE_CAPTURE_TO_STICK_ANGLES_CORE_DEFINES_SVH
`define RC_PULSE_CAPTURE_TO_STICK_ANGLES_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define RCPSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define RCPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define RCPSA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/rcpsa_pkg.sv -----
// Types and constants for the RC pulse capture and stick angle decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcpsa_pkg;

	localparam int unsigned CHANNELS_DEF = 5;
	localparam int unsigned NUM_PINS     = 5;
	localparam int unsigned TS_W         = 32;
	localparam int unsigned WIDTH_W      = 16;
	localparam int unsigned GAIN_W       = 8;
	localparam int unsigned LIMIT_W      = 15;
	localparam int unsigned CFG_INDEX_W  = 3;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam int unsigned CHAN_ROLL     = 0;
	localparam int unsigned CHAN_PITCH    = 1;
	localparam int unsigned CHAN_THROTTLE = 2;
	localparam int unsigned CHAN_YAW      = 3;
	localparam int unsigned CHAN_DRIVE    = 4;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_CENTER_WIDTH    = 3'd0;
	localparam cfg_index_t REG_DEADBAND_HALF   = 3'd1;
	localparam cfg_index_t REG_ROLL_PITCH_GAIN = 3'd2;
	localparam cfg_index_t REG_YAW_GAIN        = 3'd3;
	localparam cfg_index_t REG_ANGLE_LIMIT     = 3'd4;

	localparam logic [WIDTH_W-1:0] RST_CENTER_WIDTH    = 16'd1500;
	localparam logic [WIDTH_W-1:0] RST_DEADBAND_HALF   = 16'd50;
	localparam logic [GAIN_W-1:0]  RST_ROLL_PITCH_GAIN = 8'd6;
	localparam logic [GAIN_W-1:0]  RST_YAW_GAIN        = 8'd10;
	localparam logic [LIMIT_W-1:0] RST_ANGLE_LIMIT     = 15'd3000;

	typedef struct packed {
		logic [TS_W-1:0]     timestamp_us;
		logic [NUM_PINS-1:0] pin_levels;
	} rcpsa_in_t;

	typedef struct packed {
		logic signed [WIDTH_W-1:0] roll_angle;
		logic signed [WIDTH_W-1:0] pitch_angle;
		logic signed [WIDTH_W-1:0] yaw_angle;
		logic [WIDTH_W-1:0]        throttle_width;
		logic [WIDTH_W-1:0]        drive_width;
		logic [NUM_PINS-1:0]       pulse_done;
	} rcpsa_out_t;

endpackage

`default_nettype wire

// ----- hdl/rc_pulse_capture_to_stick_angles_core.sv -----
// Top level of the RC pulse capture and stick angle decoder.
// Depends on rcpsa_pkg and rc_pulse_capture_to_stick_angles_core_defines.svh.
// An accepted event passes through the input register, then the result register; a held result can stall it between.
// Throughput: one event per cycle; a held result stalls the input only when both registers are full.
// Structure: input register, then edge detect, width update, deadband, gain and clamp in one pass.
// Reset clears the channel levels, stored widths and valids, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "rc_pulse_capture_to_stick_angles_core_defines.svh"

module rc_pulse_capture_to_stick_angles_core
	import rcpsa_pkg::*;
#(
	parameter int unsigned CHANNELS = CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  event_valid,
	output logic                  event_stall,
	input  rcpsa_in_t             event_data,
	output logic                  result_valid,
	input  logic                  result_stall,
	output rcpsa_out_t            result_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned USED   = (CHANNELS < NUM_PINS) ? CHANNELS : NUM_PINS;
	localparam int unsigned DIFF_W = WIDTH_W + 1;
	localparam int unsigned PROD_W = DIFF_W + GAIN_W + 1;
	localparam int unsigned N_ANG  = 3;

	logic [WIDTH_W-1:0] center_q;
	logic [WIDTH_W-1:0] deadband_q;
	logic [GAIN_W-1:0]  rp_gain_q;
	logic [GAIN_W-1:0]  yaw_gain_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               valid_s1;
	rcpsa_in_t          ev_s1;

	logic [USED-1:0]    chan_high_q;
	logic [TS_W-1:0]    rise_q [USED];
	logic [WIDTH_W-1:0] pw_q   [USED];
	logic [WIDTH_W-1:0] pw_nxt [USED];
	logic [USED-1:0]    done_nxt;

	logic [WIDTH_W-1:0]  width_nxt [NUM_PINS];
	logic [NUM_PINS-1:0] done_all;

	logic                     result_valid_q;
	rcpsa_out_t               result_q;

	logic en_out, en_s1;
	logic adv_s1;

	logic [WIDTH_W-1:0]       ang_w    [N_ANG];
	logic [GAIN_W-1:0]        ang_g    [N_ANG];
	logic signed [DIFF_W-1:0] diff     [N_ANG];
	logic [DIFF_W-1:0]        mag      [N_ANG];
	logic signed [PROD_W-1:0] prod_nxt [N_ANG];
	logic signed [PROD_W-1:0] lim;
	logic signed [WIDTH_W-1:0] ang_out [N_ANG];

	// Configuration is always writable; writes beyond the register list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q   <= RST_CENTER_WIDTH;
			deadband_q <= RST_DEADBAND_HALF;
			rp_gain_q  <= RST_ROLL_PITCH_GAIN;
			yaw_gain_q <= RST_YAW_GAIN;
			limit_q    <= RST_ANGLE_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_WIDTH:    center_q   <= cfg_data[WIDTH_W-1:0];
				REG_DEADBAND_HALF:   deadband_q <= cfg_data[WIDTH_W-1:0];
				REG_ROLL_PITCH_GAIN: rp_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_YAW_GAIN:        yaw_gain_q <= cfg_data[GAIN_W-1:0];
				REG_ANGLE_LIMIT:     limit_q    <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign en_out      = !result_valid_q || !result_stall;
	assign en_s1       = !valid_s1 || en_out;
	assign adv_s1      = valid_s1 && en_out;
	assign event_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= event_valid;
			end
			if (en_out) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && event_valid) begin
			ev_s1 <= event_data;
		end
	end

	// Edge detection and width measurement for each active channel.
	always_comb begin
		logic [TS_W-1:0] span;
		for (int i = 0; i < USED; i++) begin
			span = ev_s1.timestamp_us - rise_q[i];
			done_nxt[i] = chan_high_q[i] && !ev_s1.pin_levels[i];
			if (done_nxt[i]) begin
				pw_nxt[i] = (|span[TS_W-1:WIDTH_W]) ? '1 : span[WIDTH_W-1:0];
			end else begin
				pw_nxt[i] = pw_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_high_q <= '0;
			for (int i = 0; i < USED; i++) begin
				pw_q[i] <= '0;
			end
		end else if (adv_s1) begin
			chan_high_q <= ev_s1.pin_levels[USED-1:0];
			for (int i = 0; i < USED; i++) begin
				pw_q[i] <= pw_nxt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < USED; i++) begin
				if (!chan_high_q[i] && ev_s1.pin_levels[i]) begin
					rise_q[i] <= ev_s1.timestamp_us;
				end
			end
		end
	end

	// Channels beyond the configured count read as width zero.
	always_comb begin
		for (int p = 0; p < NUM_PINS; p++) begin
			width_nxt[p] = '0;
		end
		for (int i = 0; i < USED; i++) begin
			width_nxt[i] = pw_nxt[i];
		end
		done_all = NUM_PINS'(done_nxt);
	end

	// Deadband test, gain multiply and symmetric clamp on the freshly updated widths.
	always_comb begin
		ang_w[0] = width_nxt[CHAN_ROLL];
		ang_w[1] = width_nxt[CHAN_PITCH];
		ang_w[2] = width_nxt[CHAN_YAW];
		ang_g[0] = rp_gain_q;
		ang_g[1] = rp_gain_q;
		ang_g[2] = yaw_gain_q;
		lim = $signed({{(PROD_W-LIMIT_W){1'b0}}, limit_q});
		for (int k = 0; k < N_ANG; k++) begin
			diff[k] = $signed({1'b0, ang_w[k]}) - $signed({1'b0, center_q});
			mag[k]  = diff[k][DIFF_W-1] ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
			if (mag[k] < {1'b0, deadband_q}) begin
				prod_nxt[k] = '0;
			end else begin
				prod_nxt[k] = PROD_W'(diff[k]) * PROD_W'($signed({1'b0, ang_g[k]}));
			end
			priority if (prod_nxt[k] > lim) begin
				ang_out[k] = lim[WIDTH_W-1:0];
			end else if (prod_nxt[k] < -lim) begin
				ang_out[k] = WIDTH_W'(-lim);
			end else begin
				ang_out[k] = prod_nxt[k][WIDTH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.roll_angle     <= ang_out[0];
			result_q.pitch_angle    <= ang_out[1];
			result_q.yaw_angle      <= ang_out[2];
			result_q.throttle_width <= width_nxt[CHAN_THROTTLE];
			result_q.drive_width    <= width_nxt[CHAN_DRIVE];
			result_q.pulse_done     <= done_all;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	`RCPSA_ASSERT_NEXT(a_levels_tracked, clk, arst_n, adv_s1, chan_high_q == $past(ev_s1.pin_levels[USED-1:0]))
	`RCPSA_ASSERT_IMPL(a_stall_needs_item, clk, arst_n, event_stall, valid_s1)
	`RCPSA_ASSERT_IMPL(a_result_from_s1, clk, arst_n, $rose(result_valid), $past(valid_s1))
	`RCPSA_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid && result_data == $past(result_data))

endmodule

`default_nettype wire
